// ===== hw/rtl/wino_pkg.sv =====
// Package with payload types and fixed constants of the Winograd F(2x2,3x3) transform unit.
package wino_pkg;

    localparam int FIELD_BITS = 16;
    localparam int RES_BITS   = 20;
    localparam int RES_MAX    = 524287;
    localparam int RES_MIN    = -524288;

    localparam logic [1:0] MODE_INPUT    = 2'd0;
    localparam logic [1:0] MODE_OUTPUT   = 2'd1;
    localparam logic [1:0] MODE_KERNEL   = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0]                   mode;
        logic signed [FIELD_BITS-1:0] elem0;
        logic signed [FIELD_BITS-1:0] elem1;
        logic signed [FIELD_BITS-1:0] elem2;
        logic signed [FIELD_BITS-1:0] elem3;
    } row_t;

    typedef struct packed {
        logic signed [RES_BITS-1:0] res0;
        logic signed [RES_BITS-1:0] res1;
        logic signed [RES_BITS-1:0] res2;
        logic signed [RES_BITS-1:0] res3;
        logic [1:0]                 row_index;
        logic                       last_row;
    } res_t;

endpackage

// ===== hw/rtl/winograd_f2x3_transform_unit.sv =====
// Winograd F(2x2,3x3) input, output and kernel transform unit, one tile row per transaction.
//
// A tile enters one row per transaction and the first row's mode selects the transform:
// input transform (4 rows in, 4 rows out), output transform (4 rows in, 2 rows out) or
// kernel transform (3 rows in, 4 rows out, scaled by 4). A first row with the reserved mode
// is accepted and dropped. Rows are accepted one per cycle. When the last row of a tile
// arrives, the column transform is computed and captured in a result buffer, and the result
// rows then leave one per cycle through the output register while res_ready allows, the row
// transform being applied as each row is read out. The next tile loads while this happens;
// only the last row of a tile waits, until the previous tile's last result row is sent. With
// no back-pressure an input or output tile sustains one row per cycle; kernel tiles cannot.
module winograd_f2x3_transform_unit #(
    parameter int ELEM_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          row_valid,
    output logic          row_ready,
    input  wino_pkg::row_t row_data,
    output logic          res_valid,
    input  logic          res_ready,
    output wino_pkg::res_t res_data
);

    import wino_pkg::*;

    localparam int E  = ELEM_BITS;
    localparam int MW = E + 2;
    localparam int RW = E + 4;
    localparam int SW = (RW > RES_BITS) ? RW : RES_BITS;
    localparam logic signed [SW-1:0] SAT_HI = SW'(RES_MAX);
    localparam logic signed [SW-1:0] SAT_LO = SW'(RES_MIN);

    // Rows 0..2 of the tile being loaded; the last row comes straight from the input.
    logic signed [E-1:0]  tile_reg [3][4];
    logic [1:0]           rows_loaded_reg;
    logic [1:0]           tile_mode_reg;

    logic signed [MW-1:0] m_reg [4][4];
    logic [1:0]           buf_mode_reg;
    logic                 busy_reg;
    logic [1:0]           k_reg;

    logic                 res_valid_reg;
    res_t                 res_data_reg;

    logic signed [E-1:0]  in_elem [4];
    logic signed [E-1:0]  view [4][4];
    logic signed [MW-1:0] m_next [4][4];
    logic signed [MW-1:0] a [4];
    logic signed [RW-1:0] r [4];
    res_t                 res_next;

    logic [1:0] eff_mode;
    logic       first_row;
    logic       drop_row;
    logic       completes;
    logic       accept;
    logic [1:0] last_k;
    logic       drain_adv;
    logic       drain_done;

    function automatic logic signed [RES_BITS-1:0] saturate(input logic signed [RW-1:0] v);
        logic signed [SW-1:0] w;
        w = SW'(v);
        if (w > SAT_HI)
            return RES_BITS'(SAT_HI);
        else if (w < SAT_LO)
            return RES_BITS'(SAT_LO);
        else
            return RES_BITS'(w);
    endfunction

    assign in_elem[0] = E'(row_data.elem0);
    assign in_elem[1] = E'(row_data.elem1);
    assign in_elem[2] = E'(row_data.elem2);
    assign in_elem[3] = E'(row_data.elem3);

    assign first_row = (rows_loaded_reg == 2'd0);
    assign eff_mode  = first_row ? row_data.mode : tile_mode_reg;
    assign drop_row  = first_row && (row_data.mode == MODE_RESERVED);
    assign completes = !drop_row &&
                       ((eff_mode == MODE_KERNEL) ? (rows_loaded_reg == 2'd2)
                                                  : (rows_loaded_reg == 2'd3));

    assign last_k     = (buf_mode_reg == MODE_OUTPUT) ? 2'd1 : 2'd3;
    assign drain_adv  = busy_reg && (!res_valid_reg || res_ready);
    assign drain_done = drain_adv && (k_reg == last_k);

    assign row_ready = !completes || !busy_reg || drain_done;
    assign accept    = row_valid && row_ready;

    // Full tile view with the incoming row standing in at the current row position.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                view[i][c] = (rows_loaded_reg == 2'(i)) ? in_elem[c] : tile_reg[i][c];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            view[3][c] = in_elem[c];
        end
    end

    // Column transform over the tile's rows.
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            case (eff_mode)
                MODE_INPUT:
                begin
                    m_next[0][c] = MW'(view[0][c]) - MW'(view[2][c]);
                    m_next[1][c] = MW'(view[1][c]) + MW'(view[2][c]);
                    m_next[2][c] = MW'(view[2][c]) - MW'(view[1][c]);
                    m_next[3][c] = MW'(view[3][c]) - MW'(view[1][c]);
                end
                MODE_OUTPUT:
                begin
                    m_next[0][c] = MW'(view[0][c]) + MW'(view[1][c]) + MW'(view[2][c]);
                    m_next[1][c] = MW'(view[1][c]) - MW'(view[2][c]) + MW'(view[3][c]);
                    m_next[2][c] = '0;
                    m_next[3][c] = '0;
                end
                default:
                begin
                    m_next[0][c] = MW'(view[0][c]) <<< 1;
                    m_next[1][c] = MW'(view[0][c]) + MW'(view[1][c]) + MW'(view[2][c]);
                    m_next[2][c] = MW'(view[0][c]) - MW'(view[1][c]) + MW'(view[2][c]);
                    m_next[3][c] = MW'(view[2][c]) <<< 1;
                end
            endcase
        end
    end

    // Row transform on the buffered row being sent.
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            a[c] = m_reg[k_reg][c];
        end
        case (buf_mode_reg)
            MODE_INPUT:
            begin
                r[0] = RW'(a[0]) - RW'(a[2]);
                r[1] = RW'(a[1]) + RW'(a[2]);
                r[2] = RW'(a[2]) - RW'(a[1]);
                r[3] = RW'(a[3]) - RW'(a[1]);
            end
            MODE_OUTPUT:
            begin
                r[0] = RW'(a[0]) + RW'(a[1]) + RW'(a[2]);
                r[1] = RW'(a[1]) - RW'(a[2]) + RW'(a[3]);
                r[2] = '0;
                r[3] = '0;
            end
            default:
            begin
                r[0] = RW'(a[0]) <<< 1;
                r[1] = RW'(a[0]) + RW'(a[1]) + RW'(a[2]);
                r[2] = RW'(a[0]) - RW'(a[1]) + RW'(a[2]);
                r[3] = RW'(a[2]) <<< 1;
            end
        endcase
        res_next.res0      = saturate(r[0]);
        res_next.res1      = saturate(r[1]);
        res_next.res2      = saturate(r[2]);
        res_next.res3      = saturate(r[3]);
        res_next.row_index = k_reg;
        res_next.last_row  = (k_reg == last_k);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_loaded_reg <= 2'd0;
            tile_mode_reg   <= MODE_INPUT;
            busy_reg        <= 1'b0;
            k_reg           <= 2'd0;
            buf_mode_reg    <= MODE_INPUT;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept && !drop_row)
            begin
                tile_mode_reg <= eff_mode;
                if (completes)
                    rows_loaded_reg <= 2'd0;
                else
                    rows_loaded_reg <= rows_loaded_reg + 2'd1;
            end

            // A completed tile takes the buffer as the previous one finishes.
            if (accept && completes)
            begin
                busy_reg     <= 1'b1;
                k_reg        <= 2'd0;
                buf_mode_reg <= eff_mode;
            end
            else if (drain_adv)
            begin
                k_reg <= k_reg + 2'd1;
                if (drain_done)
                    busy_reg <= 1'b0;
            end

            if (drain_adv)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !drop_row && !completes)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (rows_loaded_reg == 2'(i))
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        tile_reg[i][c] <= in_elem[c];
                    end
                end
            end
        end
        if (accept && completes)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    m_reg[i][c] <= m_next[i][c];
                end
            end
        end
        if (drain_adv)
            res_data_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// ===== tb/winograd_f2x3_transform_unit_test.sv =====
// Self-checking testbench for the Winograd F(2x2,3x3) transform unit with a built-in tile predictor.
module winograd_f2x3_transform_unit_test;
    import wino_pkg::*;

    localparam int HOLD_OFF_AT     = 35;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int TIMEOUT_CYCLES  = 200000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic row_valid = 1'b0;
    row_t row_data  = '0;
    logic res_ready = 1'b0;
    logic row_ready;
    logic res_valid;
    res_t res_data;

    row_t rows_to_send[$];
    res_t expected_res_rows[$];
    int   rows_sent      = 0;
    int   error_count    = 0;
    int   send_idle_pct  = 30;
    int   recv_idle_pct  = 84;
    int   hold_off_left  = 0;
    bit   hold_off_done  = 1'b0;

    // Shadow state of the unit: rows of the tile loaded so far and the tile's mode.
    int         rows_held = 0;
    logic [1:0] held_mode = MODE_INPUT;
    longint     tile_buf[4][4];
    res_t       want;

    winograd_f2x3_transform_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .row_valid(row_valid),
        .row_ready(row_ready),
        .row_data (row_data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_data (res_data)
    );

    always #4 clk = ~clk;

    function automatic logic signed [RES_BITS-1:0] clamp_res(longint v);
        if (v > RES_MAX)
            return RES_BITS'(RES_MAX);
        if (v < RES_MIN)
            return RES_BITS'(RES_MIN);
        return v[RES_BITS-1:0];
    endfunction

    function automatic void push_result(longint a, longint b, longint c, longint d, int idx,
                                        bit last);
        res_t r;
        r.res0      = clamp_res(a);
        r.res1      = clamp_res(b);
        r.res2      = clamp_res(c);
        r.res3      = clamp_res(d);
        r.row_index = idx[1:0];
        r.last_row  = last;
        expected_res_rows.push_back(r);
    endfunction

    // Loads one row into the shadow tile; on the tile's last row the expected result rows
    // of the selected transform are queued.
    function automatic void absorb_row(row_t r);
        longint m[4][4];
        int     cur;
        int     rows_needed;
        if (rows_held == 0)
        begin
            if (r.mode == MODE_RESERVED)
                return;
            held_mode = r.mode;
        end
        cur = rows_held;
        tile_buf[cur][0] = $signed(r.elem0);
        tile_buf[cur][1] = $signed(r.elem1);
        tile_buf[cur][2] = $signed(r.elem2);
        tile_buf[cur][3] = $signed(r.elem3);
        rows_needed = (held_mode == MODE_KERNEL) ? 3 : 4;
        if (cur + 1 < rows_needed)
        begin
            rows_held = cur + 1;
            return;
        end
        rows_held = 0;
        if (held_mode == MODE_INPUT)
        begin
            for (int c = 0; c < 4; c++)
            begin
                m[0][c] = tile_buf[0][c] - tile_buf[2][c];
                m[1][c] = tile_buf[1][c] + tile_buf[2][c];
                m[2][c] = tile_buf[2][c] - tile_buf[1][c];
                m[3][c] = tile_buf[3][c] - tile_buf[1][c];
            end
            for (int k = 0; k < 4; k++)
                push_result(m[k][0] - m[k][2], m[k][1] + m[k][2], m[k][2] - m[k][1],
                            m[k][3] - m[k][1], k, k == 3);
        end
        else if (held_mode == MODE_OUTPUT)
        begin
            for (int c = 0; c < 4; c++)
            begin
                m[0][c] = tile_buf[0][c] + tile_buf[1][c] + tile_buf[2][c];
                m[1][c] = tile_buf[1][c] - tile_buf[2][c] + tile_buf[3][c];
            end
            for (int k = 0; k < 2; k++)
                push_result(m[k][0] + m[k][1] + m[k][2], m[k][1] - m[k][2] + m[k][3], 0, 0,
                            k, k == 1);
        end
        else
        begin
            for (int c = 0; c < 3; c++)
            begin
                m[0][c] = 2 * tile_buf[0][c];
                m[1][c] = tile_buf[0][c] + tile_buf[1][c] + tile_buf[2][c];
                m[2][c] = tile_buf[0][c] - tile_buf[1][c] + tile_buf[2][c];
                m[3][c] = 2 * tile_buf[2][c];
            end
            for (int k = 0; k < 4; k++)
                push_result(2 * m[k][0], m[k][0] + m[k][1] + m[k][2],
                            m[k][0] - m[k][1] + m[k][2], 2 * m[k][2], k, k == 3);
        end
    endfunction

    task automatic check_field(input string field, input longint want_v, input longint got_v);
        if (want_v != got_v)
        begin
            $error("%s expected %0d got %0d", field, want_v, got_v);
            error_count++;
        end
    endtask

    // Row sender: offers the next pending row, holding it until the transaction completes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid <= 1'b0;
            row_data  <= '0;
        end
        else
        begin
            if (row_valid && row_ready)
            begin
                absorb_row(row_data);
                rows_sent <= rows_sent + 1;
            end
            if (!row_valid || row_ready)
            begin
                if (rows_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    row_valid <= 1'b1;
                    row_data  <= rows_to_send.pop_front();
                end
                else
                begin
                    row_valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off while the sender keeps going, so the unit backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off_left <= 0;
            hold_off_done <= 1'b0;
        end
        else if (!hold_off_done && rows_sent >= HOLD_OFF_AT)
        begin
            hold_off_left <= HOLD_OFF_CYCLES;
            hold_off_done <= 1'b1;
        end
        else if (hold_off_left != 0)
        begin
            hold_off_left <= hold_off_left - 1;
        end
    end

    // Result receiver and checker.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_res_rows.size() == 0)
                begin
                    $error("result row with no expected row waiting");
                    error_count++;
                end
                else
                begin
                    want = expected_res_rows.pop_front();
                    check_field("res0", $signed(want.res0), $signed(res_data.res0));
                    check_field("res1", $signed(want.res1), $signed(res_data.res1));
                    check_field("res2", $signed(want.res2), $signed(res_data.res2));
                    check_field("res3", $signed(want.res3), $signed(res_data.res3));
                    check_field("row_index", want.row_index, res_data.row_index);
                    check_field("last_row", want.last_row, res_data.last_row);
                end
            end
            res_ready <= (hold_off_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic signed [FIELD_BITS-1:0] rand_elem();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return FIELD_BITS'($urandom);
        endcase
    endfunction

    task automatic push_row(input logic [1:0] md, input logic signed [FIELD_BITS-1:0] e0,
                            input logic signed [FIELD_BITS-1:0] e1,
                            input logic signed [FIELD_BITS-1:0] e2,
                            input logic signed [FIELD_BITS-1:0] e3);
        row_t r;
        r.mode  = md;
        r.elem0 = e0;
        r.elem1 = e1;
        r.elem2 = e2;
        r.elem3 = e3;
        rows_to_send.push_back(r);
    endtask

    // Mostly whole tiles with random content; now and then a stray reserved-mode row.
    task automatic queue_random_rows(input int target);
        int         queued;
        int         n_rows;
        logic [1:0] md;
        queued = 0;
        while (queued < target)
        begin
            if ($urandom_range(9) == 0)
                push_row(MODE_RESERVED, rand_elem(), rand_elem(), rand_elem(), rand_elem());
            md = 2'($urandom_range(2));
            n_rows = (md == MODE_KERNEL) ? 3 : 4;
            for (int r = 0; r < n_rows; r++)
                push_row((r == 0) ? md : 2'($urandom_range(3)), rand_elem(), rand_elem(),
                         rand_elem(), rand_elem());
            queued += n_rows;
        end
    endtask

    task automatic wait_for_drain();
        while (rows_to_send.size() != 0 || row_valid)
            @(posedge clk);
        while (expected_res_rows.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic signed [FIELD_BITS-1:0] hi;
        logic signed [FIELD_BITS-1:0] lo;
        hi = 16'sh7fff;
        lo = 16'sh8000;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A reserved mode on a tile's first row is dropped.
        push_row(MODE_RESERVED, hi, lo, 16'shffff, 16'sh0000);
        // Input transform on a checkerboard of extremes; later rows carry the reserved mode.
        for (int r = 0; r < 4; r++)
            push_row((r == 0) ? MODE_INPUT : MODE_RESERVED,
                     (r % 2) ? hi : lo, (r % 2) ? lo : hi, (r % 2) ? hi : lo, (r % 2) ? lo : hi);
        // Output transform at both extremes; res2 and res3 must read zero.
        for (int r = 0; r < 4; r++)
            push_row((r == 0) ? MODE_OUTPUT : MODE_KERNEL, hi, hi, hi, hi);
        for (int r = 0; r < 4; r++)
            push_row((r == 0) ? MODE_OUTPUT : MODE_INPUT, lo, lo, lo, lo);
        // Kernel transform takes three rows and ignores column 3.
        for (int r = 0; r < 3; r++)
            push_row((r == 0) ? MODE_KERNEL : MODE_OUTPUT,
                     (r % 2) ? lo : hi, (r % 2) ? hi : lo, hi, (r % 2) ? hi : lo);
        for (int r = 0; r < 3; r++)
            push_row((r == 0) ? MODE_KERNEL : MODE_RESERVED, hi, hi, hi, lo);
        for (int r = 0; r < 4; r++)
            push_row((r == 0) ? MODE_INPUT : MODE_KERNEL, lo, lo, lo, lo);

        // The sender pauses here until every result row is back.
        wait_for_drain();
        @(negedge clk);
        queue_random_rows(26);
        wait_for_drain();

        @(negedge clk);
        send_idle_pct = 84;
        recv_idle_pct = 30;
        queue_random_rows(26);
        wait_for_drain();

        @(negedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_rows(26);
        wait_for_drain();

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("[winograd_f2x3_transform_unit] OK");
        else
            $display("[winograd_f2x3_transform_unit] ERROR");
        $finish;
    end

    initial
    begin
        #(8 * TIMEOUT_CYCLES);
        $display("[winograd_f2x3_transform_unit] ERROR");
        $finish;
    end

endmodule
